@@ sv/gsvw_pkg.sv @@
package gsvw_pkg;

    localparam int MAX_GRID_DIM    = 16;
    localparam int COORD_FRAC_BITS = 16;
    localparam int CLIP_FRAC       = 30;
    localparam int T_FRAC          = 32;
    localparam int MAX_RESULTS     = 3 * MAX_GRID_DIM - 2;

    localparam int IDX_W  = 5;
    localparam int NUM_W  = 37;
    localparam int DEN_W  = 36;
    localparam int Q_W    = 48;
    localparam int FRAC_W = 6;
    localparam int CNT_W  = 7;

    localparam logic [30:0]    CLIP_ONE   = 31'(64'd1 << CLIP_FRAC);
    localparam logic [Q_W-1:0] T_MAX      = '1;
    localparam logic [30:0]    CELL_RESET = 31'(64'd1 << COORD_FRAC_BITS);

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_PLUS  = 2'd1;
    localparam logic [1:0] DIR_MINUS = 2'd3;

    localparam logic [2:0] CFG_CELL_X = 3'd0;
    localparam logic [2:0] CFG_CELL_Y = 3'd1;
    localparam logic [2:0] CFG_CELL_Z = 3'd2;
    localparam logic [2:0] CFG_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_HEIGHT = 3'd4;
    localparam logic [2:0] CFG_DEPTH  = 3'd5;

    localparam logic [2:0] DIV_NIN  = 3'd0;
    localparam logic [2:0] DIV_NOUT = 3'd1;
    localparam logic [2:0] DIV_P1   = 3'd2;
    localparam logic [2:0] DIV_P2   = 3'd3;
    localparam logic [2:0] DIV_NUM  = 3'd4;
    localparam logic [2:0] DIV_CELL = 3'd5;

    localparam logic MUL_TEN = 1'b0;
    localparam logic MUL_TEX = 1'b1;

    localparam logic [3:0] WR_NONE = 4'd0;
    localparam logic [3:0] WR_TEN  = 4'd1;
    localparam logic [3:0] WR_TEX  = 4'd2;
    localparam logic [3:0] WR_P1   = 4'd3;
    localparam logic [3:0] WR_P2   = 4'd4;
    localparam logic [3:0] WR_IDX1 = 4'd5;
    localparam logic [3:0] WR_IDX2 = 4'd6;
    localparam logic [3:0] WR_DIR  = 4'd7;
    localparam logic [3:0] WR_NBT  = 4'd8;
    localparam logic [3:0] WR_BDT  = 4'd9;

    typedef struct packed {
        logic       load;
        logic [1:0] axis;
        logic       div_start;
        logic [2:0] div_sel;
        logic       mul_start;
        logic       mul_sel;
        logic [3:0] wr;
        logic       walk;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic d_zero;
        logic in_box;
        logic nout_neg;
        logic nin_pos;
        logic t_bad;
        logic p_eq;
        logic div_done;
        logic mul_done;
        logic walk_end;
        logic out_free;
    } stat_t;

endpackage

@@ sv/gsvw_seg_if.sv @@
interface gsvw_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

@@ sv/gsvw_vox_if.sv @@
interface gsvw_vox_if;
    logic       valid;
    logic       ready;
    logic [3:0] cell_i;
    logic [3:0] cell_j;
    logic [3:0] cell_k;
    logic       hit;
    logic       last;

    modport source (output valid, cell_i, cell_j, cell_k, hit, last, input ready);
    modport sink (input valid, cell_i, cell_j, cell_k, hit, last, output ready);
endinterface

@@ sv/gsvw_div.sv @@
module gsvw_div import gsvw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [FRAC_W-1:0] frac,
    input  logic [Q_W-1:0]   cap,
    output logic [Q_W-1:0]   q,
    output logic [DEN_W-1:0] rem,
    output logic             done
);

    logic [NUM_W-1:0] n_reg;
    logic [DEN_W-1:0] r_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg;
    logic [Q_W-1:0]   cap_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] r_next;

    // one quotient bit per cycle: restoring step
    assign trial  = {r_reg, n_reg[NUM_W-1]};
    assign diff   = trial - {1'b0, den_reg};
    assign ge     = trial >= {1'b0, den_reg};
    assign r_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W) + CNT_W'(frac);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= num;
            r_reg   <= '0;
            den_reg <= den;
            q_reg   <= '0;
            cap_reg <= cap;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[NUM_W-2:0], 1'b0};
            r_reg   <= r_next;
            q_reg   <= {q_reg[Q_W-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[Q_W-1];
        end
    end

    // saturate at the cap
    assign q    = (ovf_reg || (q_reg > cap_reg)) ? cap_reg : q_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule

@@ sv/gsvw_mul.sv @@
module gsvw_mul import gsvw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] a,
    input  logic [30:0] b,
    output logic [33:0] prod_hi,
    output logic        done
);

    logic [63:0] prod_reg;
    logic [32:0] a_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] upper;

    // shift-add, one multiplier bit per cycle, LSB first
    assign upper = {1'b0, prod_reg[63:31]} + (prod_reg[0] ? {1'b0, a_reg} : 34'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= {33'd0, b};
            a_reg    <= a;
        end
        else if (busy_reg)
        begin
            prod_reg <= {upper, prod_reg[30:1]};
        end
    end

    assign prod_hi = prod_reg[63:CLIP_FRAC];
    assign done    = done_reg;

endmodule

@@ sv/gsvw_ctrl.sv @@
module gsvw_ctrl import gsvw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  seg_valid,
    output logic  seg_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLIP_CHK = 4'd1;
    localparam logic [3:0] S_CLIP_A   = 4'd2;
    localparam logic [3:0] S_CLIP_B   = 4'd3;
    localparam logic [3:0] S_CLIP_END = 4'd4;
    localparam logic [3:0] S_SETUP    = 4'd5;
    localparam logic [3:0] S_P1       = 4'd6;
    localparam logic [3:0] S_P2       = 4'd7;
    localparam logic [3:0] S_IDX1     = 4'd8;
    localparam logic [3:0] S_IDX2     = 4'd9;
    localparam logic [3:0] S_DIR      = 4'd10;
    localparam logic [3:0] S_NBT      = 4'd11;
    localparam logic [3:0] S_BDT      = 4'd12;
    localparam logic [3:0] S_WALK     = 4'd13;
    localparam logic [3:0] S_FINISH   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       last_axis;

    assign last_axis = (axis_reg == 2'd2);

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        seg_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                seg_ready = 1'b1;
                if (seg_valid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = 2'd0;
                    state_next = S_CLIP_CHK;
                end
            end
            S_CLIP_CHK:
            begin
                if (st.d_zero)
                begin
                    if (!st.in_box)
                        state_next = S_FINISH;
                    else if (last_axis)
                        state_next = S_CLIP_END;
                    else
                        axis_next = axis_reg + 2'd1;
                end
                else if (st.nout_neg)
                    state_next = S_FINISH;
                else if (st.nin_pos)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_NIN;
                    state_next    = S_CLIP_A;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_NOUT;
                    state_next    = S_CLIP_B;
                end
            end
            S_CLIP_A:
            begin
                if (st.div_done)
                begin
                    cmd.wr        = WR_TEN;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_NOUT;
                    state_next    = S_CLIP_B;
                end
            end
            S_CLIP_B:
            begin
                if (st.div_done)
                begin
                    cmd.wr = WR_TEX;
                    if (last_axis)
                        state_next = S_CLIP_END;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_CLIP_CHK;
                    end
                end
            end
            S_CLIP_END:
            begin
                if (st.t_bad)
                    state_next = S_FINISH;
                else
                begin
                    axis_next  = 2'd0;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_TEN;
                state_next    = S_P1;
            end
            S_P1:
            begin
                if (st.mul_done)
                begin
                    cmd.wr        = WR_P1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_TEX;
                    state_next    = S_P2;
                end
            end
            S_P2:
            begin
                if (st.mul_done)
                begin
                    cmd.wr        = WR_P2;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_P1;
                    state_next    = S_IDX1;
                end
            end
            S_IDX1:
            begin
                if (st.div_done)
                begin
                    cmd.wr        = WR_IDX1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_P2;
                    state_next    = S_IDX2;
                end
            end
            S_IDX2:
            begin
                if (st.div_done)
                begin
                    cmd.wr     = WR_IDX2;
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                cmd.wr = WR_DIR;
                if (st.p_eq)
                begin
                    if (last_axis)
                        state_next = S_WALK;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_SETUP;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_NUM;
                    state_next    = S_NBT;
                end
            end
            S_NBT:
            begin
                if (st.div_done)
                begin
                    cmd.wr        = WR_NBT;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_CELL;
                    state_next    = S_BDT;
                end
            end
            S_BDT:
            begin
                if (st.div_done)
                begin
                    cmd.wr = WR_BDT;
                    if (last_axis)
                        state_next = S_WALK;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_SETUP;
                    end
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (st.walk_end)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

@@ sv/gsvw_dp.sv @@
module gsvw_dp import gsvw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    input  cmd_t               cmd,
    output stat_t              st,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         cell_i,
    output logic [3:0]         cell_j,
    output logic [3:0]         cell_k,
    output logic               hit,
    output logic               last
);

    // configuration
    logic [30:0]      cs_reg [3];
    logic [IDX_W-1:0] gd_reg [3];
    logic [30:0]      cell_eff [3];
    logic [IDX_W-1:0] dim_eff [3];

    // segment and clip state
    logic signed [31:0] s_reg [3];
    logic signed [31:0] e_reg [3];
    logic [DEN_W-1:0]   box_reg [3];
    logic [30:0]        ten_reg, tex_reg;
    logic [DEN_W-1:0]   p1_reg, p2_reg;
    logic [30:0]        rem_reg;

    // walk state
    logic [IDX_W-1:0] widx_reg [3];
    logic [IDX_W-1:0] eidx_reg [3];
    logic [1:0]       dir_reg [3];
    logic [Q_W-1:0]   nbt_reg [3];
    logic [Q_W-1:0]   bdt_reg [3];
    logic [5:0]       count_reg;
    logic             pend_valid_reg;
    logic [3:0]       pend_i_reg, pend_j_reg, pend_k_reg;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [3:0] out_i_reg, out_j_reg, out_k_reg;
    logic       out_hit_reg, out_last_reg;

    // per-axis operands
    logic [1:0]         ax;
    logic signed [31:0] s_sel, e_sel;
    logic [DEN_W-1:0]   box_sel;
    logic [30:0]        cell_sel;
    logic signed [32:0] d_sel;
    logic               d_neg;
    logic [32:0]        dmag;
    logic signed [37:0] s38, box38, nin, nout, pt, m38;
    logic [DEN_W-1:0]   pt_clamp;
    logic [DEN_W-1:0]   span;
    logic               p_up;

    // shared units
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [FRAC_W-1:0] div_frac;
    logic [Q_W-1:0]    div_cap;
    logic [Q_W-1:0]    div_q;
    logic [DEN_W-1:0]  div_rem;
    logic              div_done;
    logic [33:0]       mul_hi;
    logic              mul_done;

    // walk step
    logic [Q_W:0]   key [3];
    logic [1:0]     ax_w;
    logic           done_w;
    logic           in_grid, emit, stall, walk_go;
    logic [Q_W:0]   t_sum;
    logic [Q_W-1:0] t_sat;

    // output push
    logic       out_free, push, push_hit, push_last;
    logic [3:0] push_i, push_j, push_k;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            cell_eff[a] = (cs_reg[a] == 31'd0) ? 31'd1 : cs_reg[a];
            if (gd_reg[a] == '0)
                dim_eff[a] = IDX_W'(1);
            else if (gd_reg[a] > IDX_W'(MAX_GRID_DIM))
                dim_eff[a] = IDX_W'(MAX_GRID_DIM);
            else
                dim_eff[a] = gd_reg[a];
        end
    end

    assign ax       = cmd.axis;
    assign s_sel    = s_reg[ax];
    assign e_sel    = e_reg[ax];
    assign box_sel  = box_reg[ax];
    assign cell_sel = cell_eff[ax];

    assign d_sel = $signed({e_sel[31], e_sel}) - $signed({s_sel[31], s_sel});
    assign d_neg = d_sel[32];
    assign dmag  = d_neg ? 33'(-d_sel) : 33'(d_sel);
    assign s38   = $signed({{6{s_sel[31]}}, s_sel});
    assign box38 = $signed({2'b00, box_sel});
    assign nin   = d_neg ? (s38 - box38) : -s38;
    assign nout  = d_neg ? s38 : (box38 - s38);

    // clipped point: start plus truncated d*t, clamped into the box
    assign m38 = $signed({4'b0000, mul_hi});
    assign pt  = d_neg ? (s38 - m38) : (s38 + m38);
    always_comb
    begin
        if (pt < 0)
            pt_clamp = '0;
        else if (pt > box38)
            pt_clamp = box_sel;
        else
            pt_clamp = pt[DEN_W-1:0];
    end

    assign p_up = p1_reg < p2_reg;
    assign span = p_up ? (p2_reg - p1_reg) : (p1_reg - p2_reg);

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_NIN:
            begin
                div_num  = nin[NUM_W-1:0];
                div_den  = DEN_W'(dmag);
                div_frac = FRAC_W'(CLIP_FRAC);
                div_cap  = Q_W'(CLIP_ONE) + Q_W'(1);
            end
            DIV_NOUT:
            begin
                div_num  = nout[NUM_W-1:0];
                div_den  = DEN_W'(dmag);
                div_frac = FRAC_W'(CLIP_FRAC);
                div_cap  = Q_W'(CLIP_ONE);
            end
            DIV_P1:
            begin
                div_num  = NUM_W'(p1_reg);
                div_den  = DEN_W'(cell_sel);
                div_frac = '0;
                div_cap  = T_MAX;
            end
            DIV_P2:
            begin
                div_num  = NUM_W'(p2_reg);
                div_den  = DEN_W'(cell_sel);
                div_frac = '0;
                div_cap  = T_MAX;
            end
            DIV_NUM:
            begin
                div_num  = p_up ? NUM_W'(cell_sel - rem_reg) : NUM_W'(rem_reg);
                div_den  = span;
                div_frac = FRAC_W'(T_FRAC);
                div_cap  = T_MAX;
            end
            DIV_CELL:
            begin
                div_num  = NUM_W'(cell_sel);
                div_den  = span;
                div_frac = FRAC_W'(T_FRAC);
                div_cap  = T_MAX;
            end
            default:
            begin
                div_num  = '0;
                div_den  = '0;
                div_frac = '0;
                div_cap  = '0;
            end
        endcase
    end

    gsvw_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .frac  (div_frac),
        .cap   (div_cap),
        .q     (div_q),
        .rem   (div_rem),
        .done  (div_done)
    );

    gsvw_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (dmag),
        .b       ((cmd.mul_sel == MUL_TEX) ? tex_reg : ten_reg),
        .prod_hi (mul_hi),
        .done    (mul_done)
    );

    // walk: a still axis counts as infinitely far; ties go x, y, z
    always_comb
    begin
        for (int a = 0; a < 3; a++)
            key[a] = (dir_reg[a] == DIR_NONE) ? {1'b1, {Q_W{1'b0}}} : {1'b0, nbt_reg[a]};
    end

    always_comb
    begin
        if ((key[0] <= key[1]) && (key[0] <= key[2]))
            ax_w = 2'd0;
        else if (key[1] <= key[2])
            ax_w = 2'd1;
        else
            ax_w = 2'd2;
    end

    assign done_w  = widx_reg[ax_w] == eidx_reg[ax_w];
    assign t_sum   = {1'b0, nbt_reg[ax_w]} + {1'b0, bdt_reg[ax_w]};
    assign t_sat   = t_sum[Q_W] ? T_MAX : t_sum[Q_W-1:0];
    assign in_grid = (widx_reg[0] < dim_eff[0]) && (widx_reg[1] < dim_eff[1]) &&
                     (widx_reg[2] < dim_eff[2]);
    assign emit    = in_grid && (count_reg < 6'(MAX_RESULTS));
    assign out_free = !out_valid_reg || out_ready;
    // hold one cell back so the final one can carry last
    assign stall   = cmd.walk && emit && pend_valid_reg && !out_free;
    assign walk_go = cmd.walk && !stall;

    always_comb
    begin
        push      = 1'b0;
        push_i    = pend_i_reg;
        push_j    = pend_j_reg;
        push_k    = pend_k_reg;
        push_hit  = 1'b1;
        push_last = 1'b0;
        if (walk_go && emit && pend_valid_reg)
            push = 1'b1;
        else if (cmd.finish && out_free)
        begin
            push      = 1'b1;
            push_last = 1'b1;
            push_hit  = pend_valid_reg;
            if (!pend_valid_reg)
            begin
                push_i = '0;
                push_j = '0;
                push_k = '0;
            end
        end
    end

    always_comb
    begin
        if (push)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg[0]      <= CELL_RESET;
            cs_reg[1]      <= CELL_RESET;
            cs_reg[2]      <= CELL_RESET;
            gd_reg[0]      <= IDX_W'(1);
            gd_reg[1]      <= IDX_W'(1);
            gd_reg[2]      <= IDX_W'(1);
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CELL_X: cs_reg[0] <= cfg_data;
                    CFG_CELL_Y: cs_reg[1] <= cfg_data;
                    CFG_CELL_Z: cs_reg[2] <= cfg_data;
                    CFG_WIDTH:  gd_reg[0] <= cfg_data[IDX_W-1:0];
                    CFG_HEIGHT: gd_reg[1] <= cfg_data[IDX_W-1:0];
                    CFG_DEPTH:  gd_reg[2] <= cfg_data[IDX_W-1:0];
                    default:    ;
                endcase
            end
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                pend_valid_reg <= 1'b0;
                count_reg      <= '0;
            end
            else if (walk_go && emit)
            begin
                pend_valid_reg <= 1'b1;
                count_reg      <= count_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg[0] <= start_x;
            s_reg[1] <= start_y;
            s_reg[2] <= start_z;
            e_reg[0] <= end_x;
            e_reg[1] <= end_y;
            e_reg[2] <= end_z;
            for (int a = 0; a < 3; a++)
                box_reg[a] <= DEN_W'(cell_eff[a]) * DEN_W'(dim_eff[a]);
            ten_reg <= '0;
            tex_reg <= CLIP_ONE;
        end

        unique case (cmd.wr)
            WR_TEN:
            begin
                if (div_q[30:0] > ten_reg)
                    ten_reg <= div_q[30:0];
            end
            WR_TEX:
            begin
                if (div_q[30:0] < tex_reg)
                    tex_reg <= div_q[30:0];
            end
            WR_P1:   p1_reg <= pt_clamp;
            WR_P2:   p2_reg <= pt_clamp;
            WR_IDX1:
            begin
                widx_reg[ax] <= div_q[IDX_W-1:0];
                rem_reg      <= div_rem[30:0];
            end
            WR_IDX2: eidx_reg[ax] <= div_q[IDX_W-1:0];
            WR_DIR:
            begin
                if (p_up)
                    dir_reg[ax] <= DIR_PLUS;
                else if (p1_reg > p2_reg)
                    dir_reg[ax] <= DIR_MINUS;
                else
                    dir_reg[ax] <= DIR_NONE;
                nbt_reg[ax] <= '0;
                bdt_reg[ax] <= '0;
            end
            WR_NBT:  nbt_reg[ax] <= div_q;
            WR_BDT:  bdt_reg[ax] <= div_q;
            default: ;
        endcase

        // advance along the nearest boundary
        if (walk_go && !done_w)
        begin
            nbt_reg[ax_w] <= t_sat;
            if (dir_reg[ax_w] == DIR_PLUS)
                widx_reg[ax_w] <= widx_reg[ax_w] + IDX_W'(1);
            else
                widx_reg[ax_w] <= widx_reg[ax_w] - IDX_W'(1);
        end

        if (walk_go && emit)
        begin
            pend_i_reg <= widx_reg[0][3:0];
            pend_j_reg <= widx_reg[1][3:0];
            pend_k_reg <= widx_reg[2][3:0];
        end

        if (push)
        begin
            out_i_reg    <= push_i;
            out_j_reg    <= push_j;
            out_k_reg    <= push_k;
            out_hit_reg  <= push_hit;
            out_last_reg <= push_last;
        end
    end

    assign st.d_zero   = (d_sel == 33'sd0);
    assign st.in_box   = !s_sel[31] && (s38 <= box38);
    assign st.nout_neg = nout[37];
    assign st.nin_pos  = !nin[37] && (nin != 38'sd0);
    assign st.t_bad    = ten_reg > tex_reg;
    assign st.p_eq     = p1_reg == p2_reg;
    assign st.div_done = div_done;
    assign st.mul_done = mul_done;
    assign st.walk_end = walk_go && done_w;
    assign st.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign cell_i    = out_i_reg;
    assign cell_j    = out_j_reg;
    assign cell_k    = out_k_reg;
    assign hit       = out_hit_reg;
    assign last      = out_last_reg;

endmodule

@@ sv/grid_segment_voxel_walk_unit.sv @@
// Segment voxel walk: accepts one 3D segment (signed Q16.16, grid-local) per transfer on
// seg and returns, in walk order, every in-grid cell it crosses on voxel, the final
// transfer of a segment flagged with last; a segment that misses the grid, or whose walk
// touches no in-grid cell, returns a single transfer with hit low and last high. The
// segment is first clipped against the box [0, cell_size*dim] on each axis, then walked
// Amanatides-Woo style with ties resolved x, then y, then z; at most 46 cells come back
// per segment. One segment is in flight at a time: seg.ready is high only while the unit
// is idle. Clipping and per-axis walk setup share one restoring divider and one shift-add
// multiplier; the walk then takes one cycle per visited cell, plus any cycles voxel.ready
// is held low. Write the cell size and grid dimension registers only while no segment is
// in flight; a cell size of zero acts as one lsb and a grid dimension of zero or above 16
// is clamped into 1..16.
module grid_segment_voxel_walk_unit import gsvw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    gsvw_seg_if.sink    seg,
    gsvw_vox_if.source  voxel
);

    cmd_t  cmd;
    stat_t st;

    // sequencing: clip, per-axis setup, walk, final transfer
    gsvw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg.valid),
        .seg_ready (seg.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // arithmetic, walk state and the output register
    gsvw_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start_x   (seg.start_x),
        .start_y   (seg.start_y),
        .start_z   (seg.start_z),
        .end_x     (seg.end_x),
        .end_y     (seg.end_y),
        .end_z     (seg.end_z),
        .cmd       (cmd),
        .st        (st),
        .out_valid (voxel.valid),
        .out_ready (voxel.ready),
        .cell_i    (voxel.cell_i),
        .cell_j    (voxel.cell_j),
        .cell_k    (voxel.cell_k),
        .hit       (voxel.hit),
        .last      (voxel.last)
    );

    // a segment is taken only from idle, so ready drops right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (seg.valid && seg.ready) |=> !seg.ready)
        else $error("segment accepted while another is in flight");

    // a miss is always the closing transfer
    a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (voxel.valid && !voxel.hit) |-> voxel.last)
        else $error("miss result without last");

    // returning to idle leaves the closing result in the output register
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(seg.ready) |-> (voxel.valid && voxel.last))
        else $error("unit idle without a closing result");

endmodule
